FILE: hdl/msel_pkg.sv
// shared types and constants for the mode rotation selector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package msel_pkg;

    // field and port widths
    localparam int MODE_W      = 4;
    localparam int COUNT_W     = 8;
    localparam int GATE_W      = 16;
    localparam int TABLE_W     = 28;
    localparam int BUDGETS_W   = 24;
    localparam int TDATA_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 28;

    // entries that the table register can hold; higher entries read as zero
    localparam int TABLE_SLOTS    = TABLE_W / MODE_W;
    localparam int NUM_COUNTERS   = 6;
    localparam int CNT_SEL_W      = 3;
    // ungated walk gives up after this many rounds of the table
    localparam int UNGATED_ROUNDS = 129;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_TERM  = 4'd12;
    localparam logic [MODE_W-1:0] MODE_FIRST = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LAST  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_NONE  = 4'd0;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GATED_ENABLE  = 3'd0,
        REG_GATE_DURATION = 3'd1,
        REG_MODE_TABLE    = 3'd2,
        REG_PRIMARY_COUNT = 3'd3,
        REG_SUB_BUDGETS   = 3'd4,
        REG_MPLEX_COUNT   = 3'd5,
        REG_PPV_COUNT     = 3'd6
    } cfg_reg_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic emit;
    } msel_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic imm;
        logic done;
        logic out_free;
    } msel_stat_t;

endpackage

FILE: hdl/msel_ctrl.sv
// controller state machine of the mode rotation selector
// depends on msel_pkg; drives the datapath through msel_cmd_t
`timescale 1ns / 1ps

module msel_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output msel_pkg::msel_cmd_t cmd,
    input  msel_pkg::msel_stat_t stat
);
    import msel_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.imm ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a finished walk always leads to the result hand-off
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.done) |=> (state_reg == ST_DONE))
        else $error("scan finished without moving to result hand-off");
    // a word is only emitted when the output stage can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted into a full output stage");
    // commands are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.emit}))
        else $error("more than one command at once");
`endif

endmodule

FILE: hdl/msel_dpath.sv
// datapath of the mode rotation selector: configuration registers,
// table walk, skip counters, gate countdown and output register; uses msel_pkg
`timescale 1ns / 1ps

module msel_dpath #(
    parameter int TABLE_ENTRIES = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [msel_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msel_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_request,
    input  msel_pkg::msel_cmd_t                  cmd,
    output msel_pkg::msel_stat_t                 stat,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [msel_pkg::TDATA_W-1:0]         m_tdata
);
    import msel_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int STEP_W = $clog2(UNGATED_ROUNDS * TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [STEP_W-1:0] GATE_LAST  = STEP_W'(TABLE_ENTRIES - 1);
    localparam logic [STEP_W-1:0] UNG_LAST   = STEP_W'(UNGATED_ROUNDS * TABLE_ENTRIES - 1);

    // configuration registers
    logic                  gated_enable_reg;
    logic [GATE_W-1:0]     gate_duration_reg;
    logic [TABLE_W-1:0]    mode_table_reg;
    logic [COUNT_W-1:0]    primary_count_reg;
    logic [BUDGETS_W-1:0]  sub_budgets_reg;
    logic [COUNT_W-1:0]    mplex_count_reg;
    logic [COUNT_W-1:0]    ppv_count_reg;

    // walk state
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      start_idx_reg;
    logic [GATE_W-1:0]     countdown_reg, countdown_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  scan_gated_reg;
    logic [COUNT_W-1:0]    skip_reg [NUM_COUNTERS];
    logic [MODE_W-1:0]     result_reg, result_next;

    // output register
    logic                  out_valid_reg;
    logic [MODE_W-1:0]     out_mode_reg;

    // walk signals
    logic [MODE_W-1:0]     entries [TABLE_ENTRIES];
    logic [MODE_W-1:0]     cur_mode;
    logic [MODE_W-1:0]     slot;
    logic [CNT_SEL_W-1:0]  k;
    logic                  in_band;
    logic [COUNT_W-1:0]    reload;
    logic [COUNT_W-1:0]    cnt_dec;
    logic [IDX_W-1:0]      idx_step;
    logic                  gated_hit, gated_done;
    logic                  ung_pos, ung_accept, ung_done;
    logic                  start_scan;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gated_enable_reg  <= 1'b0;
            gate_duration_reg <= '0;
            mode_table_reg    <= TABLE_W'(MODE_TERM);
            primary_count_reg <= '0;
            sub_budgets_reg   <= '0;
            mplex_count_reg   <= '0;
            ppv_count_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GATED_ENABLE:  gated_enable_reg  <= cfg_data[0];
                REG_GATE_DURATION: gate_duration_reg <= cfg_data[GATE_W-1:0];
                REG_MODE_TABLE:    mode_table_reg    <= cfg_data[TABLE_W-1:0];
                REG_PRIMARY_COUNT: primary_count_reg <= cfg_data[COUNT_W-1:0];
                REG_SUB_BUDGETS:   sub_budgets_reg   <= cfg_data[BUDGETS_W-1:0];
                REG_MPLEX_COUNT:   mplex_count_reg   <= cfg_data[COUNT_W-1:0];
                REG_PPV_COUNT:     ppv_count_reg     <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // table entries; those beyond the register read as zero
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_entry
        if (i < TABLE_SLOTS)
        begin : g_real
            assign entries[i] = mode_table_reg[i*MODE_W +: MODE_W];
        end
        else
        begin : g_empty
            assign entries[i] = MODE_NONE;
        end
    end

    // current entry and index advance
    assign cur_mode = entries[idx_reg];
    assign idx_step = (cur_mode == MODE_TERM || idx_reg == IDX_LAST) ?
                      '0 : idx_reg + 1'b1;
    assign in_band  = (cur_mode >= MODE_FIRST) && (cur_mode <= MODE_LAST);
    assign slot     = cur_mode - MODE_FIRST;
    assign k        = slot[CNT_SEL_W-1:0];

    // reload byte of the selected counter
    always_comb
    begin
        case (k)
            3'd0:    reload = primary_count_reg;
            3'd1:    reload = sub_budgets_reg[7:0];
            3'd2:    reload = sub_budgets_reg[15:8];
            3'd3:    reload = sub_budgets_reg[23:16];
            3'd4:    reload = mplex_count_reg;
            default: reload = ppv_count_reg;
        endcase
    end

    assign cnt_dec = in_band ? skip_reg[k] - 1'b1 : '0;

    // gated walk: first mode in band with a nonzero count
    assign gated_hit  = in_band && (reload != '0);
    assign gated_done = gated_hit || (idx_step == start_idx_reg) || (step_reg == GATE_LAST);

    // ungated walk: skip counter runs down to zero or below
    assign ung_pos    = in_band && !reload[COUNT_W-1] && (reload != '0);
    assign ung_accept = ung_pos && (cnt_dec[COUNT_W-1] || cnt_dec == '0);
    assign ung_done   = (cur_mode == MODE_TERM) || ung_accept || (step_reg == UNG_LAST);

    // start decision, result and status
    always_comb
    begin
        stat.imm       = 1'b0;
        stat.done      = 1'b0;
        stat.out_free  = !out_valid_reg || m_tready;
        start_scan     = 1'b0;
        result_next    = result_reg;
        countdown_next = countdown_reg;
        idx_next       = idx_reg;
        if (cmd.start)
        begin
            if (!in_request)
            begin
                stat.imm    = 1'b1;
                result_next = MODE_NONE;
            end
            else if (gated_enable_reg)
            begin
                if (gate_duration_reg == '0)
                begin
                    stat.imm    = 1'b1;
                    result_next = MODE_TERM;
                end
                else if (countdown_reg != '0)
                begin
                    stat.imm       = 1'b1;
                    result_next    = MODE_TERM;
                    countdown_next = countdown_reg - 1'b1;
                end
                else
                begin
                    start_scan     = 1'b1;
                    countdown_next = gate_duration_reg;
                end
            end
            else
            begin
                start_scan = 1'b1;
            end
        end
        else if (cmd.step)
        begin
            idx_next = idx_step;
            if (scan_gated_reg)
            begin
                stat.done   = gated_done;
                result_next = gated_hit ? cur_mode : MODE_TERM;
            end
            else
            begin
                stat.done   = ung_done;
                result_next = ung_accept ? cur_mode : MODE_TERM;
            end
        end
    end

    // walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            start_idx_reg  <= '0;
            countdown_reg  <= '0;
            step_reg       <= '0;
            scan_gated_reg <= 1'b0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                skip_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg       <= idx_next;
            countdown_reg <= countdown_next;
            if (start_scan)
            begin
                start_idx_reg  <= idx_reg;
                step_reg       <= '0;
                scan_gated_reg <= gated_enable_reg;
            end
            else if (cmd.step)
            begin
                step_reg <= step_reg + 1'b1;
                if (!scan_gated_reg && ung_pos)
                begin
                    skip_reg[k] <= ung_accept ? reload : cnt_dec;
                end
            end
        end
    end

    // result holding register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_mode_reg <= result_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - MODE_W){1'b0}}, out_mode_reg};

`ifndef SYNTHESIS
    // the table index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("table index beyond last entry");
    // a gated walk ends within one round of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && scan_gated_reg) |-> (step_reg <= GATE_LAST))
        else $error("gated walk ran past one round");
    // an emitted result shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (m_tvalid && m_tdata[MODE_W-1:0] == $past(result_reg)))
        else $error("emitted result missing on output");
`endif

endmodule

FILE: hdl/mode_rotation_selector_core.sv
// top level of the mode rotation selector: controller plus datapath
// depends on msel_pkg, msel_ctrl and msel_dpath
`timescale 1ns / 1ps

// Usage
// s_* channel: one word per request, tdata bit 0 = request. A request of 0
//   returns mode 0 at once; a request of 1 selects the next display mode.
// m_* channel: one word per accepted input word, tdata bits 3..0 = mode.
// cfg_* channel: register writes (index, data), always ready; write only while
//   the block is idle. Indexes 0..6: gated_enable, gate_duration, mode_table,
//   primary_count, sub_budgets, mplex_count, ppv_count; others are ignored.
// Timing: one word is handled at a time. An idle request, a forced mode 12 or
//   a zero gate passes from accept into the result register, then into the
//   output register once that is free. A gated scan walks one table entry
//   per cycle, up to TABLE_ENTRIES entries. An ungated walk also takes one
//   entry per cycle and may go on for 129 * TABLE_ENTRIES entries before giving
//   mode 12. The table walk through the single entry read port sets the rate.
// A result sits in an output register, so the next word is accepted while it
//   waits; if the receiver stalls, a second finished result holds the block
//   until the output register empties.
// Reset clears the controller, counters, index and countdown, and sets all
//   configuration registers to zero except mode_table, which resets to 12.

module mode_rotation_selector_core #(
    parameter int TABLE_ENTRIES = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [msel_pkg::TDATA_W-1:0]     s_tdata,   // [0] request
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msel_pkg::TDATA_W-1:0]     m_tdata,   // [3:0] selected_mode
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [msel_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import msel_pkg::*;

    msel_cmd_t  cmd;
    msel_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencing
    msel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // registers, walk and output stage
    msel_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_request (s_tdata[0]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: bench/tb.sv
// self-checking bench for mode_rotation_selector_core: directed table, then random phases
// depends on msel_pkg and mode_rotation_selector_core; predicts each selection itself unless a directed row fixes it
`timescale 1ns / 1ps

module tb;

    import msel_pkg::*;

    localparam int TABLE_ENTRIES = 7;
    localparam int ITEM_TARGET   = 1950;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_CAP    = 100;
    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SKIPPED   = MODE_LAST + 4'd1;

    typedef struct packed {
        logic                   is_write;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   req;
        logic                   fixed;
        logic [MODE_W-1:0]      mode;
    } bench_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // register mirror
    logic                  cfg_gated   = 1'b0;
    logic [GATE_W-1:0]     cfg_gate    = '0;
    logic [TABLE_W-1:0]    cfg_table   = TABLE_W'(MODE_TERM);
    logic [COUNT_W-1:0]    cfg_primary = '0;
    logic [BUDGETS_W-1:0]  cfg_budgets = '0;
    logic [COUNT_W-1:0]    cfg_mplex   = '0;
    logic [COUNT_W-1:0]    cfg_ppv     = '0;

    // selector state mirror
    int                       walk_index = 0;
    logic [GATE_W-1:0]        gate_left  = '0;
    logic signed [COUNT_W-1:0] skip_count [NUM_COUNTERS] = '{default: '0};

    logic [MODE_W-1:0] expected_modes [$];
    bench_row_t        opening_rows [$];
    logic              row_fixed;
    logic [MODE_W-1:0] row_mode;
    logic [MODE_W-1:0] fresh_mode;
    logic [MODE_W-1:0] due_mode;
    int unsigned       requests_sent  = 0;
    int unsigned       results_seen   = 0;
    int unsigned       failures       = 0;
    int unsigned       quiet_cycles   = 0;
    int                send_gap_pct   = 0;
    int                recv_stall_pct = 0;

    mode_rotation_selector_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [0] request
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [3:0] selected_mode
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_GATED_ENABLE:  cfg_gated   = value[0];
            REG_GATE_DURATION: cfg_gate    = value[GATE_W-1:0];
            REG_MODE_TABLE:    cfg_table   = value[TABLE_W-1:0];
            REG_PRIMARY_COUNT: cfg_primary = value[COUNT_W-1:0];
            REG_SUB_BUDGETS:   cfg_budgets = value[BUDGETS_W-1:0];
            REG_MPLEX_COUNT:   cfg_mplex   = value[COUNT_W-1:0];
            REG_PPV_COUNT:     cfg_ppv     = value[COUNT_W-1:0];
            default:           ;
        endcase
    endfunction

    // count byte behind counter k, for mode 5 + k
    function automatic logic [COUNT_W-1:0] reload_value(input int k);
        case (k)
            0:       return cfg_primary;
            1:       return cfg_budgets[7:0];
            2:       return cfg_budgets[15:8];
            3:       return cfg_budgets[23:16];
            4:       return cfg_mplex;
            default: return cfg_ppv;
        endcase
    endfunction

    // read the entry under the index and move the index on
    function automatic logic [MODE_W-1:0] read_entry();
        logic [MODE_W-1:0] code;
        code = (walk_index < TABLE_SLOTS) ? cfg_table[MODE_W*walk_index +: MODE_W] : MODE_NONE;
        if (code == MODE_TERM || walk_index + 1 >= TABLE_ENTRIES)
            walk_index = 0;
        else
            walk_index = walk_index + 1;
        return code;
    endfunction

    function automatic logic [MODE_W-1:0] gated_pick();
        int                start_at;
        int                n;
        logic [MODE_W-1:0] code;
        if (cfg_gate == '0)
            return MODE_TERM;
        if (gate_left != '0)
        begin
            gate_left = gate_left - 1'b1;
            return MODE_TERM;
        end
        start_at  = walk_index;
        gate_left = cfg_gate;
        // one lap at most; a terminator may send the index home before it gets round
        for (n = 0; n < TABLE_ENTRIES; n++)
        begin
            code = read_entry();
            if (code >= MODE_FIRST && code <= MODE_LAST &&
                reload_value(int'(code) - int'(MODE_FIRST)) != '0)
                return code;
            if (walk_index == start_at)
                break;
        end
        return MODE_TERM;
    endfunction

    function automatic logic [MODE_W-1:0] skip_pick();
        int                        n;
        int                        k;
        logic [MODE_W-1:0]         code;
        logic signed [COUNT_W-1:0] reload;
        logic signed [COUNT_W-1:0] left;
        for (n = 0; n < UNGATED_ROUNDS * TABLE_ENTRIES; n++)
        begin
            code = read_entry();
            if (code == MODE_TERM)
                return code;
            if (code >= MODE_FIRST && code <= MODE_LAST)
            begin
                k      = int'(code) - int'(MODE_FIRST);
                reload = reload_value(k);
                // only a positive reload arms the counter; decrement wraps as a byte
                if (reload > 0)
                begin
                    left = skip_count[k] - 8'sd1;
                    if (left <= 0)
                    begin
                        skip_count[k] = reload;
                        return code;
                    end
                    skip_count[k] = left;
                end
            end
        end
        return MODE_TERM;
    endfunction

    function automatic logic [MODE_W-1:0] predict_mode(input logic req);
        if (!req)
            return MODE_NONE;
        return cfg_gated ? gated_pick() : skip_pick();
    endfunction

    // ---------------------------------------------------------------- monitor

    // mirror writes, predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
        if (s_tvalid && s_tready)
        begin
            fresh_mode = predict_mode(s_tdata[0]);
            expected_modes.push_back(row_fixed ? row_mode : fresh_mode);
        end
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_modes.size() == 0)
            begin
                if (failures < REPORT_CAP)
                    $error("selected_mode: expected nothing, actual %0d", m_tdata[MODE_W-1:0]);
                failures++;
            end
            else
            begin
                due_mode = expected_modes.pop_front();
                if (m_tdata[MODE_W-1:0] !== due_mode)
                begin
                    if (failures < REPORT_CAP)
                        $error("selected_mode: expected %0d, actual %0d",
                               due_mode, m_tdata[MODE_W-1:0]);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("mode_rotation_selector_core regression: fail");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- drivers

    // leaves cfg_valid high so back-to-back writes never drop it
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic push_request(input logic req, input logic fixed, input logic [MODE_W-1:0] mode);
        if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(TDATA_W-1){1'b0}}, req};
        row_fixed <= fixed;
        row_mode  <= mode;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        requests_sent++;
    endtask

    // hold the sender until every selection is back, then let the block settle
    task automatic wait_for_results(input int settle);
        s_tvalid <= 1'b0;
        while (results_seen < requests_sent)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        opening_rows.push_back('{1'b1, idx, value, 1'b0, 1'b0, MODE_NONE});
    endfunction

    function automatic void add_request(input logic req, input logic fixed,
                                        input logic [MODE_W-1:0] mode);
        opening_rows.push_back('{1'b0, REG_SPARE, '0, req, fixed, mode});
    endfunction

    function automatic logic [MODE_W-1:0] random_code();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return MODE_FIRST + MODE_W'($urandom_range(0, MODE_LAST - MODE_FIRST));
        if (pick < 15)
            return MODE_TERM;
        if (pick < 17)
            return MODE_SKIPPED;
        return MODE_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        case ($urandom_range(0, 11))
            0:       return 8'h7f;
            1:       return 8'h80;
            2:       return COUNT_W'($urandom_range(0, 255));
            3, 4:    return '0;
            default: return COUNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic int burst_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // one random setting followed by a burst of requests
    task automatic run_phase(input int count, input bit calm, input bit long_gate);
        logic                 gated;
        logic [GATE_W-1:0]    dur;
        logic [TABLE_W-1:0]   tbl;
        logic [CFG_DATA_W-1:0] noise;
        int                   slot;
        wait_for_results(4);
        send_gap_pct   = calm ? 0 : burst_rate();
        recv_stall_pct = calm ? 0 : burst_rate();
        gated = long_gate || ($urandom_range(0, 99) < 35);
        // a long gate freezes the gated walk for the rest of the run, so only at the end
        if (long_gate)
            dur = '1;
        else
            case ($urandom_range(0, 7))
                0:       dur = '0;
                1:       dur = GATE_W'($urandom_range(5, 12));
                default: dur = GATE_W'($urandom_range(1, 4));
            endcase
        for (slot = 0; slot < TABLE_SLOTS; slot++)
            tbl[MODE_W*slot +: MODE_W] = random_code();
        // usually plant a terminator so ungated walks stay short
        if ($urandom_range(0, 9) < 8)
        begin
            slot = $urandom_range(0, TABLE_ENTRIES - 1);
            tbl[MODE_W*slot +: MODE_W] = MODE_TERM;
        end
        noise = CFG_DATA_W'($urandom);
        write_register(REG_GATED_ENABLE, {noise[CFG_DATA_W-1:1], gated});
        write_register(REG_GATE_DURATION, {noise[CFG_DATA_W-1:GATE_W], dur});
        write_register(REG_MODE_TABLE, tbl);
        noise = CFG_DATA_W'($urandom);
        write_register(REG_PRIMARY_COUNT, {noise[CFG_DATA_W-1:COUNT_W], random_count()});
        write_register(REG_SUB_BUDGETS, {noise[CFG_DATA_W-1:BUDGETS_W], random_count(),
                                         random_count(), random_count()});
        write_register(REG_MPLEX_COUNT, {noise[CFG_DATA_W-1:COUNT_W], random_count()});
        write_register(REG_PPV_COUNT, {noise[CFG_DATA_W-1:COUNT_W], random_count()});
        if ($urandom_range(0, 3) == 0)
            write_register(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        repeat (count)
            push_request($urandom_range(0, 7) != 0, 1'b0, MODE_NONE);
    endtask

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        bench_row_t row;
        logic       was_write;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        row_fixed <= 1'b0;
        row_mode  <= MODE_NONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight after reset: idle word, then the reset table's terminator
        add_request(1'b0, 1'b1, MODE_NONE);
        add_request(1'b1, 1'b1, MODE_TERM);
        // gated with a zero gate
        add_write(REG_GATED_ENABLE, 28'h0000001);
        add_request(1'b1, 1'b1, MODE_TERM);
        // gated scans with skipped codes, a wrap past the terminator, count extremes
        add_write(REG_GATE_DURATION, 28'h0000001);
        add_write(REG_MODE_TABLE, 28'hac0d6b5);
        add_write(REG_PRIMARY_COUNT, 28'h000007f);
        add_write(REG_SUB_BUDGETS, 28'h0800001);
        add_write(REG_MPLEX_COUNT, 28'h0000080);
        add_write(REG_PPV_COUNT, 28'h00000ff);
        add_request(1'b1, 1'b1, MODE_FIRST);
        add_request(1'b1, 1'b1, MODE_TERM);
        add_request(1'b1, 1'b0, MODE_NONE);
        add_request(1'b1, 1'b1, MODE_TERM);
        add_request(1'b1, 1'b0, MODE_NONE);
        add_request(1'b0, 1'b1, MODE_NONE);
        // empty table: countdown first, then a full lap with nothing to take
        add_write(REG_MODE_TABLE, 28'h0000000);
        add_request(1'b1, 1'b1, MODE_TERM);
        add_request(1'b1, 1'b1, MODE_TERM);
        // terminator in entry 0 stops the lap from ever returning
        add_write(REG_MODE_TABLE, 28'h568b97c);
        add_write(REG_PRIMARY_COUNT, 28'h0000000);
        add_write(REG_SUB_BUDGETS, 28'h0000000);
        add_write(REG_MPLEX_COUNT, 28'h0000000);
        add_request(1'b1, 1'b1, MODE_TERM);
        add_request(1'b1, 1'b1, MODE_TERM);
        // skip-counter rotation, with a write to the spare index
        add_write(REG_GATED_ENABLE, 28'hffffffe);
        add_write(REG_MODE_TABLE, 28'hca98765);
        add_write(REG_PRIMARY_COUNT, 28'h0000002);
        add_write(REG_SUB_BUDGETS, 28'h0038001);
        add_write(REG_MPLEX_COUNT, 28'h000007f);
        add_write(REG_PPV_COUNT, 28'h0000000);
        add_write(REG_SPARE, 28'hfffffff);
        repeat (6)
            add_request(1'b1, 1'b0, MODE_NONE);
        // nothing acceptable: the walk runs out and gives the terminator
        add_write(REG_MODE_TABLE, 28'hbbbbbbb);
        add_request(1'b1, 1'b1, MODE_TERM);
        add_write(REG_MODE_TABLE, 28'hfffffff);
        add_request(1'b1, 1'b1, MODE_TERM);
        // negative reload never arms the counter
        add_write(REG_PRIMARY_COUNT, 28'h0000080);
        add_write(REG_MODE_TABLE, 28'h555c555);
        add_request(1'b1, 1'b0, MODE_NONE);

        was_write = 1'b0;
        foreach (opening_rows[i])
        begin
            row = opening_rows[i];
            if (row.is_write)
            begin
                if (!was_write)
                    wait_for_results(4);
                write_register(row.reg_idx, row.value);
            end
            else
            begin
                if (was_write)
                    cfg_valid <= 1'b0;
                push_request(row.req, row.fixed, row.mode);
            end
            was_write = row.is_write;
        end

        // random settings, then a calm tail ending on the longest gate
        while (requests_sent < ITEM_TARGET - 150)
            run_phase($urandom_range(40, 140), 1'b0, 1'b0);
        run_phase(90, 1'b1, 1'b0);
        run_phase(60, 1'b1, 1'b1);
        wait_for_results(16);

        if (failures == 0)
            $display("mode_rotation_selector_core regression: pass");
        else
            $display("mode_rotation_selector_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hdl/msel_pkg.sv
hdl/msel_ctrl.sv
hdl/msel_dpath.sv
hdl/mode_rotation_selector_core.sv
bench/tb.sv
